/* sv/sgt_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes, colors and status types for the scope grid trace renderer.
// Depends on nothing; every other file imports it.
package sgt_pkg;

    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int SPAN_W     = 16;
    localparam int TIDX_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int MASK_W     = 6;
    localparam int COLOR_W    = 16;
    localparam int CLASS_W    = 4;
    localparam int LANE_W     = 9;
    localparam int MAX_TRACES = 6;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRACE_MASK = 3'd4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 16'h0000;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 16'hFFE0;

    localparam logic [COLOR_W-1:0] TRACE_PALETTE [MAX_TRACES] = '{
        16'hF800, 16'h07E0, 16'h001F, 16'h07FF, 16'hFC00, 16'hF81F
    };

    localparam logic [CLASS_W-1:0] CLASS_BG     = 4'd0;
    localparam logic [CLASS_W-1:0] CLASS_GRID   = 4'd1;
    localparam logic [CLASS_W-1:0] CLASS_AXIS   = 4'd2;
    localparam logic [CLASS_W-1:0] CLASS_TRACE0 = 4'd3;

    typedef struct packed {
        logic valid;
        logic on_screen;
        logic on_x;
        logic on_y;
        logic axis_x;
        logic axis_y;
    } grid_status_t;

endpackage

/* sv/scope_grid_trace_pixel_render.sv */
`timescale 1ns / 1ps
// Top level of the oscilloscope pixel renderer: configuration, handshakes and color selection.
// Depends on sgt_pkg, sgt_span_mem and sgt_grid_pipe.
//
//  Channel  | Signals                                              | Direction
//  ---------+------------------------------------------------------+----------
//  input    | in_valid, in_ready, kind, trace_index, column, row,   | in
//           | span_low, span_high                                  |
//  output   | out_valid, out_ready, pixel_color, pixel_class       | out
//  config   | cfg_we, cfg_index, cfg_data                          | in
//
// One transfer is taken every cycle unless a result waits on out_ready; a query passes through
// the input stage that also reads the span memories, nine remainder stages and the output
// register.
// Span writes to an in-range trace and column go into the per-trace memories and produce no result.
// Reset restores the configuration defaults and empties the pipeline; the span memories
// keep their contents. While a result waits on out_ready the whole pipeline holds.
module scope_grid_trace_pixel_render
    import sgt_pkg::*;
#(
    parameter int TRACE_COUNT   = 4,
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [TIDX_W-1:0]     trace_index,
    input  logic [COL_W-1:0]      column,
    input  logic [ROW_W-1:0]      row,
    input  logic [ROW_W-1:0]      span_low,
    input  logic [ROW_W-1:0]      span_high,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic [CLASS_W-1:0]    pixel_class
);

    logic [COL_W-1:0]  grid_x_reg, grid_x_next;
    logic [ROW_W-1:0]  grid_y_reg, grid_y_next;
    logic [COL_W-1:0]  center_col_reg, center_col_next;
    logic [ROW_W-1:0]  center_row_reg, center_row_next;
    logic [MASK_W-1:0] mask_reg, mask_next;

    logic                   out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]     color_reg, color_next;
    logic [CLASS_W-1:0]     class_reg, class_next;

    logic                   en;
    logic                   in_fire;
    logic                   col_in_range;
    logic                   on_screen;
    logic                   wr_en;
    logic                   query;
    logic [TRACE_COUNT-1:0] hits;
    grid_status_t           status;

    assign en           = !out_valid_reg || out_ready;
    assign in_ready     = en;
    assign in_fire      = in_valid && in_ready;
    assign col_in_range = int'(column) < SCREEN_WIDTH;
    assign on_screen    = col_in_range && (int'(row) < SCREEN_HEIGHT);
    assign query        = in_fire && kind == KIND_QUERY;
    assign wr_en        = in_fire && kind == KIND_WRITE && col_in_range
                          && int'(trace_index) < TRACE_COUNT;

    always_comb
    begin
        grid_x_next     = grid_x_reg;
        grid_y_next     = grid_y_reg;
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        mask_next       = mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_X:     grid_x_next     = cfg_data;
                REG_GRID_Y:     grid_y_next     = cfg_data[ROW_W-1:0];
                REG_CENTER_COL: center_col_next = cfg_data;
                REG_CENTER_ROW: center_row_next = cfg_data[ROW_W-1:0];
                REG_TRACE_MASK: mask_next       = cfg_data[MASK_W-1:0];
                default:        mask_next       = mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg     <= COL_W'(50);
            grid_y_reg     <= ROW_W'(50);
            center_col_reg <= COL_W'(SCREEN_WIDTH / 2);
            center_row_reg <= ROW_W'(SCREEN_HEIGHT / 2);
            mask_reg       <= '0;
        end
        else
        begin
            grid_x_reg     <= grid_x_next;
            grid_y_reg     <= grid_y_next;
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            mask_reg       <= mask_next;
        end
    end

    sgt_span_mem #(
        .TRACE_COUNT  (TRACE_COUNT),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_span_mem (
        .clk          (clk),
        .en           (en),
        .wr_en        (wr_en),
        .wr_trace     (trace_index),
        .column       (column),
        .col_in_range (col_in_range),
        .row          (row),
        .span_low     (span_low),
        .span_high    (span_high),
        .trace_mask   (mask_reg),
        .hits         (hits)
    );

    sgt_grid_pipe u_grid_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .load          (query),
        .on_screen     (on_screen),
        .column        (column),
        .row           (row),
        .center_column (center_col_reg),
        .center_row    (center_row_reg),
        .x_spacing     (grid_x_reg),
        .y_spacing     (grid_y_reg),
        .status        (status)
    );

    // Horizontal lines win over vertical ones, and higher trace indexes win last.
    always_comb
    begin
        color_next     = COLOR_BLACK;
        class_next     = CLASS_BG;
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = status.valid;
        end
        if (status.on_screen)
        begin
            if (status.on_x)
            begin
                color_next = status.axis_x ? COLOR_WHITE : COLOR_YELLOW;
                class_next = status.axis_x ? CLASS_AXIS : CLASS_GRID;
            end
            if (status.on_y)
            begin
                color_next = status.axis_y ? COLOR_WHITE : COLOR_YELLOW;
                class_next = status.axis_y ? CLASS_AXIS : CLASS_GRID;
            end
            for (int t = 0; t < TRACE_COUNT; t++)
            begin
                if (hits[t])
                begin
                    color_next = TRACE_PALETTE[t];
                    class_next = CLASS_TRACE0 + CLASS_W'(t);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg <= color_next;
            class_reg <= class_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;
    assign pixel_class = class_reg;

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(pixel_class) < int'(CLASS_TRACE0) + TRACE_COUNT)
        else $error("pixel class beyond the last trace");

    a_background_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_class == CLASS_BG |-> pixel_color == COLOR_BLACK)
        else $error("background pixel is not black");

    a_axis_white: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_class == CLASS_AXIS |-> pixel_color == COLOR_WHITE)
        else $error("center axis pixel is not white");

    a_grid_yellow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_class == CLASS_GRID |-> pixel_color == COLOR_YELLOW)
        else $error("grid pixel is not yellow");

endmodule

/* sv/sgt_span_mem.sv */
`timescale 1ns / 1ps
// Per-trace span memories with a registered read and the delayed row coverage flags.
// Depends on sgt_pkg.
module sgt_span_mem
    import sgt_pkg::*;
#(
    parameter int TRACE_COUNT  = 4,
    parameter int SCREEN_WIDTH = 320
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic                   wr_en,
    input  logic [TIDX_W-1:0]      wr_trace,
    input  logic [COL_W-1:0]       column,
    input  logic                   col_in_range,
    input  logic [ROW_W-1:0]       row,
    input  logic [ROW_W-1:0]       span_low,
    input  logic [ROW_W-1:0]       span_high,
    input  logic [MASK_W-1:0]      trace_mask,
    output logic [TRACE_COUNT-1:0] hits
);

    localparam int AW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;

    logic [AW-1:0]          addr;
    logic [SPAN_W-1:0]      rd_reg [TRACE_COUNT];
    logic [ROW_W-1:0]       row_reg;
    logic [TRACE_COUNT-1:0] hit_now;
    logic [TRACE_COUNT-1:0] hit_reg [1:LANE_W];

    assign addr = col_in_range ? column[AW-1:0] : '0;

    for (genvar t = 0; t < TRACE_COUNT; t++) begin : g_trace
        logic [SPAN_W-1:0] mem [SCREEN_WIDTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && wr_trace == TIDX_W'(t))
            begin
                mem[addr] <= {span_high, span_low};
            end
            if (en)
            begin
                rd_reg[t] <= mem[addr];
            end
        end

        assign hit_now[t] = trace_mask[t]
                            && row_reg >= rd_reg[t][ROW_W-1:0]
                            && row_reg <= rd_reg[t][SPAN_W-1:ROW_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_reg    <= row;
            hit_reg[1] <= hit_now;
            for (int s = 2; s <= LANE_W; s++)
            begin
                hit_reg[s] <= hit_reg[s-1];
            end
        end
    end

    assign hits = hit_reg[LANE_W];

endmodule

/* sv/sgt_grid_pipe.sv */
`timescale 1ns / 1ps
// Pipelined remainder test that decides whether a pixel lies on a vertical or horizontal grid line.
// Depends on sgt_pkg; one bit of the distance is consumed per stage for both axes.
module sgt_grid_pipe
    import sgt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               load,
    input  logic               on_screen,
    input  logic [COL_W-1:0]   column,
    input  logic [ROW_W-1:0]   row,
    input  logic [COL_W-1:0]   center_column,
    input  logic [ROW_W-1:0]   center_row,
    input  logic [COL_W-1:0]   x_spacing,
    input  logic [ROW_W-1:0]   y_spacing,
    output grid_status_t       status
);

    logic              vld_reg [0:LANE_W];
    logic              scr_reg [0:LANE_W];
    logic              axx_reg [0:LANE_W];
    logic              axy_reg [0:LANE_W];
    logic [LANE_W-1:0] dx_reg  [0:LANE_W];
    logic [LANE_W-1:0] dy_reg  [0:LANE_W];
    logic [LANE_W-1:0] rx_reg  [0:LANE_W];
    logic [LANE_W-1:0] ry_reg  [0:LANE_W];
    logic [LANE_W-1:0] rx_next [0:LANE_W-1];
    logic [LANE_W-1:0] ry_next [0:LANE_W-1];

    logic [LANE_W-1:0] dx_in;
    logic [LANE_W-1:0] dy_in;
    logic [LANE_W:0]   spx;
    logic [LANE_W:0]   spy;

    // The distance to the center is divisible by the spacing exactly when
    // both positions share a remainder.
    assign dx_in = (column >= center_column) ? LANE_W'(column - center_column)
                                             : LANE_W'(center_column - column);
    assign dy_in = (row >= center_row) ? LANE_W'(row - center_row)
                                       : LANE_W'(center_row - row);
    assign spx = (LANE_W + 1)'(x_spacing);
    assign spy = (LANE_W + 1)'(y_spacing);

    always_comb
    begin
        logic [LANE_W:0] shx;
        logic [LANE_W:0] shy;
        for (int s = 0; s < LANE_W; s++)
        begin
            shx = {rx_reg[s], dx_reg[s][LANE_W-1-s]};
            shy = {ry_reg[s], dy_reg[s][LANE_W-1-s]};
            rx_next[s] = (shx >= spx) ? LANE_W'(shx - spx) : shx[LANE_W-1:0];
            ry_next[s] = (shy >= spy) ? LANE_W'(shy - spy) : shy[LANE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LANE_W; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= load;
            for (int s = 1; s <= LANE_W; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scr_reg[0] <= on_screen;
            axx_reg[0] <= (column == center_column);
            axy_reg[0] <= (row == center_row);
            dx_reg[0]  <= dx_in;
            dy_reg[0]  <= dy_in;
            rx_reg[0]  <= '0;
            ry_reg[0]  <= '0;
            for (int s = 1; s <= LANE_W; s++)
            begin
                scr_reg[s] <= scr_reg[s-1];
                axx_reg[s] <= axx_reg[s-1];
                axy_reg[s] <= axy_reg[s-1];
                dx_reg[s]  <= dx_reg[s-1];
                dy_reg[s]  <= dy_reg[s-1];
                rx_reg[s]  <= rx_next[s-1];
                ry_reg[s]  <= ry_next[s-1];
            end
        end
    end

    assign status.valid     = vld_reg[LANE_W];
    assign status.on_screen = scr_reg[LANE_W];
    assign status.axis_x    = axx_reg[LANE_W];
    assign status.axis_y    = axy_reg[LANE_W];
    assign status.on_x      = (x_spacing == '0) ? axx_reg[LANE_W] : (rx_reg[LANE_W] == '0);
    assign status.on_y      = (y_spacing == '0) ? axy_reg[LANE_W] : (ry_reg[LANE_W] == '0);

endmodule

/* dv/tb_scope_grid_trace_pixel_render.sv */
`timescale 1ns / 1ps
// Self-checking testbench for scope_grid_trace_pixel_render: a directed plan, then random phases
// under varying register settings, each result checked against a planned or predicted pixel.
// Depends on sgt_pkg and the renderer RTL.
module tb_scope_grid_trace_pixel_render;
    import sgt_pkg::*;

    localparam int TRACE_COUNT   = 4;
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int ITEM_TARGET   = 1900;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct {
        logic                kind;
        logic [TIDX_W-1:0]   trace_index;
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    span_low;
        logic [ROW_W-1:0]    span_high;
    } pixel_req_t;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [CLASS_W-1:0] cls;
    } pixel_t;

    typedef enum logic {PLAN_REGS, PLAN_ITEM} plan_op_t;

    typedef struct {
        plan_op_t              op;
        logic [CFG_DATA_W-1:0] gx;
        logic [CFG_DATA_W-1:0] gy;
        logic [CFG_DATA_W-1:0] cc;
        logic [CFG_DATA_W-1:0] cr;
        logic [CFG_DATA_W-1:0] mask;
        pixel_req_t            req;
        bit                    typed;
        pixel_t                px;
    } plan_row_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW} sink_mode_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  kind        = KIND_WRITE;
    logic [TIDX_W-1:0]     trace_index = '0;
    logic [COL_W-1:0]      column      = '0;
    logic [ROW_W-1:0]      row         = '0;
    logic [ROW_W-1:0]      span_low    = '0;
    logic [ROW_W-1:0]      span_high   = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [COLOR_W-1:0]    pixel_color;
    logic [CLASS_W-1:0]    pixel_class;

    logic [SPAN_W-1:0]     span_store  [TRACE_COUNT*SCREEN_WIDTH];
    bit                    span_loaded [TRACE_COUNT*SCREEN_WIDTH];
    logic [COL_W-1:0]      grid_x      = 9'd50;
    logic [ROW_W-1:0]      grid_y      = 8'd50;
    logic [COL_W-1:0]      axis_col    = COL_W'(SCREEN_WIDTH / 2);
    logic [ROW_W-1:0]      axis_row    = ROW_W'(SCREEN_HEIGHT / 2);
    logic [MASK_W-1:0]     trace_mask  = '0;

    pixel_t     pending_pixels [$];
    plan_row_t  directed_plan  [$];
    pixel_t     pixel_due;
    int         mismatches     = 0;
    int         transfers_in   = 0;
    int         pixels_checked = 0;
    int         settings_used  = 1;
    int         burst_left     = 0;
    int         pending_gap    = 0;
    bit         valid_high     = 1'b0;
    bit         steady_flow    = 1'b0;
    sink_mode_t sink_mode      = SINK_OPEN;
    int         sink_left      = 0;

    scope_grid_trace_pixel_render #(
        .TRACE_COUNT   (TRACE_COUNT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .trace_index (trace_index),
        .column      (column),
        .row         (row),
        .span_low    (span_low),
        .span_high   (span_high),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .pixel_class (pixel_class)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout with %0d pixels still expected", pending_pixels.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit on_line(int unsigned pos, int unsigned centre, int unsigned spacing);
        if (spacing == 0)
        begin
            return pos == centre;
        end
        return (pos % spacing) == (centre % spacing);
    endfunction

    function automatic pixel_t shade_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] rw);
        pixel_t            px;
        logic [SPAN_W-1:0] span;
        px.color = COLOR_BLACK;
        px.cls   = CLASS_BG;
        if (col < SCREEN_WIDTH && rw < SCREEN_HEIGHT)
        begin
            if (on_line(col, axis_col, grid_x))
            begin
                px.color = (col == axis_col) ? COLOR_WHITE : COLOR_YELLOW;
                px.cls   = (col == axis_col) ? CLASS_AXIS : CLASS_GRID;
            end
            if (on_line(rw, axis_row, grid_y))
            begin
                px.color = (rw == axis_row) ? COLOR_WHITE : COLOR_YELLOW;
                px.cls   = (rw == axis_row) ? CLASS_AXIS : CLASS_GRID;
            end
            for (int t = 0; t < TRACE_COUNT; t++)
            begin
                if (trace_mask[t])
                begin
                    span = span_store[t*SCREEN_WIDTH + col];
                    if (rw >= span[ROW_W-1:0] && rw <= span[SPAN_W-1:ROW_W])
                    begin
                        px.color = TRACE_PALETTE[t];
                        px.cls   = CLASS_W'(CLASS_TRACE0 + t);
                    end
                end
            end
        end
        return px;
    endfunction

    function automatic void store_span(pixel_req_t req);
        if (req.trace_index < TRACE_COUNT && req.column < SCREEN_WIDTH)
        begin
            span_store[req.trace_index*SCREEN_WIDTH + req.column]  = {req.span_high, req.span_low};
            span_loaded[req.trace_index*SCREEN_WIDTH + req.column] = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
        begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic send_item(input pixel_req_t req, input bit typed, input pixel_t typed_px);
        if (pending_gap > 0)
        begin
            repeat (pending_gap) @(posedge clk);
            pending_gap = 0;
        end
        in_valid    <= 1'b1;
        kind        <= req.kind;
        trace_index <= req.trace_index;
        column      <= req.column;
        row         <= req.row;
        span_low    <= req.span_low;
        span_high   <= req.span_high;
        valid_high  = 1'b1;
        do @(posedge clk); while (!in_ready);
        transfers_in++;
        if (req.kind == KIND_WRITE)
        begin
            store_span(req);
        end
        else
        begin
            pending_pixels.push_back(typed ? typed_px : shade_pixel(req.column, req.row));
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if (!steady_flow && $urandom_range(0, 3) != 0)
            begin
                pending_gap = $urandom_range(1, 24);
                in_valid   <= 1'b0;
                valid_high = 1'b0;
            end
        end
    endtask

    task automatic stop_sending();
        if (valid_high)
        begin
            in_valid   <= 1'b0;
            valid_high = 1'b0;
        end
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] gx, gy, cc, cr, mask);
        logic [CFG_IDX_W-1:0]  idx_list  [6];
        logic [CFG_DATA_W-1:0] data_list [6];
        idx_list  = '{CFG_IDX_W'($urandom_range(REG_TRACE_MASK + 1, (1 << CFG_IDX_W) - 1)),
                      REG_GRID_X, REG_GRID_Y, REG_CENTER_COL, REG_CENTER_ROW, REG_TRACE_MASK};
        data_list = '{CFG_DATA_W'($urandom), gx, gy, cc, cr, mask};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data_list[i];
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        grid_x     = gx[COL_W-1:0];
        grid_y     = gy[ROW_W-1:0];
        axis_col   = cc[COL_W-1:0];
        axis_row   = cr[ROW_W-1:0];
        trace_mask = mask[MASK_W-1:0];
        settings_used++;
    endtask

    function automatic void plan_regs(logic [CFG_DATA_W-1:0] gx, gy, cc, cr, mask);
        plan_row_t r;
        r.op   = PLAN_REGS;
        r.gx   = gx;
        r.gy   = gy;
        r.cc   = cc;
        r.cr   = cr;
        r.mask = mask;
        directed_plan.push_back(r);
    endfunction

    function automatic void plan_item(logic k, int unsigned t, int unsigned col, int unsigned rw,
                                      int unsigned lo, int unsigned hi, bit typed,
                                      logic [COLOR_W-1:0] color, logic [CLASS_W-1:0] cls);
        plan_row_t r;
        r.op              = PLAN_ITEM;
        r.req.kind        = k;
        r.req.trace_index = TIDX_W'(t);
        r.req.column      = COL_W'(col);
        r.req.row         = ROW_W'(rw);
        r.req.span_low    = ROW_W'(lo);
        r.req.span_high   = ROW_W'(hi);
        r.typed           = typed;
        r.px.color        = color;
        r.px.cls          = cls;
        directed_plan.push_back(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg(int unsigned top);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_DATA_W'(top);
            2: return CFG_DATA_W'(1);
            3: return CFG_DATA_W'($urandom_range(1, 63));
            default: return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
        endcase
    endfunction

    task automatic fill_spans(input logic [COL_W-1:0] col);
        pixel_req_t w;
        pixel_t     none;
        none = '{COLOR_BLACK, CLASS_BG};
        for (int t = 0; t < TRACE_COUNT; t++)
        begin
            if (trace_mask[t] && !span_loaded[t*SCREEN_WIDTH + col])
            begin
                w.kind        = KIND_WRITE;
                w.trace_index = TIDX_W'(t);
                w.column      = col;
                w.row         = ROW_W'($urandom);
                w.span_low    = ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
                w.span_high   = ROW_W'($urandom_range(w.span_low, (1 << ROW_W) - 1));
                send_item(w, 1'b0, none);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            sink_left = $urandom_range(20, 200);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN: out_ready <= 1'b1;
            SINK_COIN: out_ready <= ($urandom_range(0, 3) != 0);
            default:   out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            pixels_checked++;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected pixel, color %h class %0d",
                                          pixel_color, pixel_class));
            end
            else
            begin
                pixel_due = pending_pixels.pop_front();
                if (pixel_color !== pixel_due.color)
                begin
                    report_mismatch($sformatf("pixel_color %h, expected %h",
                                              pixel_color, pixel_due.color));
                end
                if (pixel_class !== pixel_due.cls)
                begin
                    report_mismatch($sformatf("pixel_class %0d, expected %0d",
                                              pixel_class, pixel_due.cls));
                end
            end
        end
    end

    initial
    begin
        pixel_req_t req;
        pixel_t     none;
        int         phase_len;
        int         query_pct;
        none = '{COLOR_BLACK, CLASS_BG};

        // Reset defaults first, then each register setting listed below in turn.
        plan_item(KIND_QUERY, 0, 0, 0, 0, 0, 1'b1, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 160, 0, 0, 0, 1'b1, COLOR_WHITE, CLASS_AXIS);
        plan_item(KIND_QUERY, 0, 10, 0, 0, 0, 1'b1, COLOR_YELLOW, CLASS_GRID);
        plan_item(KIND_QUERY, 0, 0, 120, 0, 0, 1'b1, COLOR_WHITE, CLASS_AXIS);
        plan_item(KIND_QUERY, 0, 0, 20, 0, 0, 1'b1, COLOR_YELLOW, CLASS_GRID);
        plan_item(KIND_QUERY, 0, 160, 70, 0, 0, 1'b1, COLOR_YELLOW, CLASS_GRID);
        plan_item(KIND_QUERY, 7, 511, 255, 255, 255, 1'b1, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 320, 120, 0, 0, 1'b1, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 160, 240, 0, 0, 1'b1, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 7, 0, 0, 0, 255, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 4, 5, 0, 0, 255, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 0, 320, 0, 0, 255, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 0, 0, 0, 0, 255, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 1, 0, 0, 100, 140, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 2, 0, 0, 200, 100, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_WRITE, 3, 0, 0, 230, 255, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_regs(9'd50, 9'd50, 9'd160, 9'd120, 9'h03F);
        plan_item(KIND_QUERY, 0, 0, 120, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 0, 200, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 0, 239, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 400, 100, 0, 0, 1'b1, COLOR_BLACK, CLASS_BG);
        plan_regs(9'd0, 9'd0, 9'd511, 9'd255, 9'd0);
        plan_item(KIND_QUERY, 0, 200, 100, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 511, 255, 0, 0, 1'b1, COLOR_BLACK, CLASS_BG);
        plan_regs(9'd1, 9'd1, 9'd0, 9'd0, 9'd0);
        plan_item(KIND_QUERY, 0, 0, 0, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 5, 7, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_regs(9'd511, 9'd255, 9'd319, 9'd239, 9'h030);
        plan_item(KIND_QUERY, 0, 319, 100, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);
        plan_item(KIND_QUERY, 0, 0, 239, 0, 0, 1'b0, COLOR_BLACK, CLASS_BG);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].op == PLAN_REGS)
            begin
                stop_sending();
                wait_idle();
                program_regs(directed_plan[i].gx, directed_plan[i].gy, directed_plan[i].cc,
                             directed_plan[i].cr, directed_plan[i].mask);
            end
            else
            begin
                send_item(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].px);
            end
        end

        while (transfers_in < ITEM_TARGET)
        begin
            stop_sending();
            wait_idle();
            program_regs(pick_reg(511), pick_reg(255), pick_reg(SCREEN_WIDTH - 1),
                         pick_reg(SCREEN_HEIGHT - 1), pick_reg(63));
            steady_flow = ($urandom_range(0, 3) == 0);
            query_pct   = $urandom_range(30, 85);
            phase_len   = $urandom_range(100, 220);
            for (int n = 0; n < phase_len && transfers_in < ITEM_TARGET; n++)
            begin
                req.kind        = ($urandom_range(0, 99) < query_pct) ? KIND_QUERY : KIND_WRITE;
                req.trace_index = ($urandom_range(0, 9) == 0) ? TIDX_W'($urandom)
                                  : TIDX_W'($urandom_range(0, TRACE_COUNT - 1));
                req.column      = ($urandom_range(0, 9) == 0) ? COL_W'($urandom)
                                  : COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
                req.row         = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom)
                                  : ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
                req.span_low    = ROW_W'($urandom);
                req.span_high   = ROW_W'($urandom);
                if ($urandom_range(0, 3) != 0)
                begin
                    req.span_low  = ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
                    req.span_high = ROW_W'($urandom_range(req.span_low, (1 << ROW_W) - 1));
                end
                if (req.kind == KIND_QUERY && req.column < SCREEN_WIDTH)
                begin
                    fill_spans(req.column);
                end
                send_item(req, 1'b0, none);
            end
        end

        stop_sending();
        wait_idle();
        $display("%0d transfers in, %0d pixels checked across %0d register settings",
                 transfers_in, pixels_checked, settings_used);
        $display("covered grid, axis, trace priority, off-screen and ignored writes");
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
